/* rtl/core/hps_pkg.sv */
// Shared constants, types and codes of the heading PID steering block.
package hps_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int SHIFT = 4 + GAIN_FRAC_BITS;

    localparam int MODE_W = 2;
    localparam int HEAD_W = 13;
    localparam int ERR_W = 13;
    localparam int DIFF_W = ERR_W + 1;
    localparam int SUM_W = 32;
    localparam int GAIN_W = 16;
    localparam int ANGLE_W = 8;
    localparam int LIMIT_W = 7;
    localparam int SPEED_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = SUM_W;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W = PROD_W + 3;
    localparam int CLAMP_W = ACC_W - SHIFT + 1;
    localparam int EDGE_W = ANGLE_W + 2;

    localparam int DIV_NUM_W = 2 * SPEED_W;
    localparam int DIV_DEN_W = LIMIT_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    localparam logic signed [DIFF_W-1:0] WRAP_HALF = DIFF_W'(2880);
    localparam logic signed [DIFF_W-1:0] WRAP_FULL = DIFF_W'(5760);
    localparam logic signed [CLAMP_W-1:0] SERVO_MAX = CLAMP_W'(180);

    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVADE_LEFT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVADE_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_EVADE_OFFSET = 3'd7;

    localparam logic [GAIN_W-1:0] RST_GAIN_P = 16'd538;
    localparam logic [GAIN_W-1:0] RST_GAIN_I = 16'd0;
    localparam logic [GAIN_W-1:0] RST_GAIN_D = 16'd205;
    localparam logic [ANGLE_W-1:0] RST_SERVO_CENTER = 8'd90;
    localparam logic [LIMIT_W-1:0] RST_STEER_LIMIT = 7'd50;
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 8'd120;
    localparam logic [SPEED_W-1:0] RST_MIN_SPEED = 8'd40;
    localparam logic [LIMIT_W-1:0] RST_EVADE_OFFSET = 7'd40;

    typedef struct packed {
        logic clr;
        logic en;
        logic sub;
    } t_mac_ctl;

endpackage

/* rtl/core/hps_in_if.sv */
// Input channel of the heading PID steering block: one control tick per item.
interface hps_in_if;
    logic valid;
    logic ready;
    logic [hps_pkg::MODE_W-1:0] mode;
    logic [hps_pkg::HEAD_W-1:0] heading;
    logic [hps_pkg::HEAD_W-1:0] target_heading;

    modport source(output valid, output mode, output heading, output target_heading,
                   input ready);
    modport sink(input valid, input mode, input heading, input target_heading,
                 output ready);
endinterface

/* rtl/core/hps_out_if.sv */
// Output channel of the heading PID steering block: one steering command per item.
interface hps_out_if;
    logic valid;
    logic ready;
    logic [hps_pkg::ANGLE_W-1:0] servo_angle;
    logic [hps_pkg::SPEED_W-1:0] motor_speed;
    logic signed [hps_pkg::ERR_W-1:0] heading_error;

    modport source(output valid, output servo_angle, output motor_speed,
                   output heading_error, input ready);
    modport sink(input valid, input servo_angle, input motor_speed,
                 input heading_error, output ready);
endinterface

/* rtl/core/hps_mac.sv */
// Shared multiply-accumulate unit with a registered product stage.
module hps_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hps_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [hps_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [hps_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [hps_pkg::ACC_W-1:0]    o_acc
);

    logic signed [hps_pkg::PROD_W-1:0] w_prod;
    logic signed [hps_pkg::PROD_W-1:0] r_prod;
    logic signed [hps_pkg::ACC_W-1:0]  r_acc;
    logic signed [hps_pkg::ACC_W-1:0]  w_prod_ext;
    logic                              r_pend;
    logic                              r_psub;

    assign w_prod = hps_pkg::PROD_W'(i_a) * hps_pkg::PROD_W'(i_b);
    assign w_prod_ext = hps_pkg::ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_psub <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pend <= i_ctl.en;
            r_psub <= i_ctl.sub;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_pend) begin
                r_acc <= r_psub ? (r_acc - w_prod_ext) : (r_acc + w_prod_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_prod <= w_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/core/hps_div.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
module hps_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [hps_pkg::DIV_NUM_W-1:0]   i_num,
    input  logic [hps_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                            o_busy,
    output logic [hps_pkg::DIV_NUM_W-1:0]   o_quot
);

    logic [hps_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [hps_pkg::DIV_NUM_W-1:0] r_quo;
    logic [hps_pkg::DIV_DEN_W-1:0] r_rem;
    logic [hps_pkg::DIV_DEN_W-1:0] r_den;
    logic [hps_pkg::DIV_DEN_W:0]   w_trial;
    logic                          w_ge;
    logic [hps_pkg::DIV_DEN_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[hps_pkg::DIV_NUM_W-1]};
    assign w_ge = (w_trial >= {1'b0, r_den});
    assign w_diff = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= hps_pkg::DIV_CNT_W'(hps_pkg::DIV_NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[hps_pkg::DIV_NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[hps_pkg::DIV_DEN_W-1:0]
                          : w_trial[hps_pkg::DIV_DEN_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quo;

endmodule

/* rtl/core/heading_pid_steering.sv */
// Heading PID steering controller: sequencer, state and configuration registers.
//
// One input item is one control tick carrying a mode, a measured heading and a
// target heading. The block returns one item with servo angle, motor speed and
// the wrapped heading error. The user writes configuration through a plain write
// port (enable, index, data) while the block is idle; the block does not enforce it.
//
// A hold-mode item goes from acceptance through WRAP, SUM, MAC_P, MAC_I, MAC_D,
// DRAIN, SERVO, SPD_MUL, SPD_ACC, DIV_GO and DIV to DONE: the three PID products
// go one after another through a single 17 by 32 bit multiply-accumulate unit,
// and the speed quotient comes out of a restoring divider at one bit per cycle.
// An evade-mode item goes from acceptance through SERVO to DONE. The input is
// ready only while the sequencer is idle, so one item is in work at a time.
//
// The result sits in an output register. A new item is accepted while that
// result waits; if the receiver still stalls when the next result is done, the
// sequencer holds it until the output register is free.
//
// Synchronous reset restores the register defaults and clears the error sum,
// the previous error and any pending result.
module heading_pid_steering (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hps_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [hps_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    hps_in_if.sink                              i_in,
    hps_out_if.source                           o_out
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WRAP    = 4'd1;
    localparam logic [3:0] S_SUM     = 4'd2;
    localparam logic [3:0] S_MAC_P   = 4'd3;
    localparam logic [3:0] S_MAC_I   = 4'd4;
    localparam logic [3:0] S_MAC_D   = 4'd5;
    localparam logic [3:0] S_DRAIN   = 4'd6;
    localparam logic [3:0] S_SERVO   = 4'd7;
    localparam logic [3:0] S_SPD_MUL = 4'd8;
    localparam logic [3:0] S_SPD_ACC = 4'd9;
    localparam logic [3:0] S_DIV_GO  = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    logic [hps_pkg::GAIN_W-1:0]  r_gain_p;
    logic [hps_pkg::GAIN_W-1:0]  r_gain_i;
    logic [hps_pkg::GAIN_W-1:0]  r_gain_d;
    logic [hps_pkg::ANGLE_W-1:0] r_center;
    logic [hps_pkg::LIMIT_W-1:0] r_limit;
    logic [hps_pkg::SPEED_W-1:0] r_cruise;
    logic [hps_pkg::SPEED_W-1:0] r_min;
    logic [hps_pkg::LIMIT_W-1:0] r_offset;

    logic [hps_pkg::MODE_W-1:0]       r_mode;
    logic [hps_pkg::HEAD_W-1:0]       r_head;
    logic [hps_pkg::HEAD_W-1:0]       r_tgt;
    logic signed [hps_pkg::ERR_W-1:0] r_err;
    logic signed [hps_pkg::SUM_W-1:0] r_sum;
    logic signed [hps_pkg::ERR_W-1:0] r_prev;
    logic [hps_pkg::ANGLE_W-1:0]      r_servo;

    logic                              r_ov;
    logic [hps_pkg::ANGLE_W-1:0]       r_out_servo;
    logic [hps_pkg::SPEED_W-1:0]       r_out_speed;
    logic signed [hps_pkg::ERR_W-1:0]  r_out_err;

    logic w_accept;
    logic w_evade;
    logic w_fire;

    logic signed [hps_pkg::DIFF_W-1:0] w_raw;
    logic signed [hps_pkg::DIFF_W-1:0] w_wrap;
    logic signed [hps_pkg::SUM_W:0]    w_sum_ext;
    logic signed [hps_pkg::SUM_W-1:0]  w_sum_sat;
    logic signed [hps_pkg::DIFF_W-1:0] w_diff;

    hps_pkg::t_mac_ctl                  w_mac_ctl;
    logic signed [hps_pkg::MUL_A_W-1:0] w_mac_a;
    logic signed [hps_pkg::MUL_B_W-1:0] w_mac_b;
    logic signed [hps_pkg::ACC_W-1:0]   w_acc;

    logic signed [hps_pkg::ACC_W-1:0]   w_floor;
    logic signed [hps_pkg::CLAMP_W-1:0] w_hold_a;
    logic signed [hps_pkg::EDGE_W-1:0]  w_evade_a;
    logic signed [hps_pkg::EDGE_W-1:0]  w_lo_e;
    logic signed [hps_pkg::EDGE_W-1:0]  w_hi_e;
    logic signed [hps_pkg::CLAMP_W-1:0] w_a;
    logic signed [hps_pkg::CLAMP_W-1:0] w_a1;
    logic signed [hps_pkg::CLAMP_W-1:0] w_a2;
    logic signed [hps_pkg::CLAMP_W-1:0] w_a3;

    logic signed [hps_pkg::ANGLE_W:0]   w_dev_s;
    logic [hps_pkg::ANGLE_W-1:0]        w_dev;
    logic                               w_spd_ok;
    logic [hps_pkg::SPEED_W-1:0]        w_spd_diff;
    logic                               w_div_busy;
    logic [hps_pkg::DIV_NUM_W-1:0]      w_quot;
    logic [hps_pkg::DIV_NUM_W:0]        w_spd_sum;
    logic [hps_pkg::SPEED_W-1:0]        w_speed;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_evade = (r_mode == hps_pkg::MODE_EVADE_LEFT) ||
                     (r_mode == hps_pkg::MODE_EVADE_RIGHT);
    assign w_fire = (r_state == S_DONE) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= hps_pkg::RST_GAIN_P;
            r_gain_i <= hps_pkg::RST_GAIN_I;
            r_gain_d <= hps_pkg::RST_GAIN_D;
            r_center <= hps_pkg::RST_SERVO_CENTER;
            r_limit <= hps_pkg::RST_STEER_LIMIT;
            r_cruise <= hps_pkg::RST_CRUISE_SPEED;
            r_min <= hps_pkg::RST_MIN_SPEED;
            r_offset <= hps_pkg::RST_EVADE_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hps_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data;
                hps_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data;
                hps_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data;
                hps_pkg::CFG_SERVO_CENTER: r_center <= i_cfg_data[hps_pkg::ANGLE_W-1:0];
                hps_pkg::CFG_STEER_LIMIT: r_limit <= i_cfg_data[hps_pkg::LIMIT_W-1:0];
                hps_pkg::CFG_CRUISE_SPEED: r_cruise <= i_cfg_data[hps_pkg::SPEED_W-1:0];
                hps_pkg::CFG_MIN_SPEED: r_min <= i_cfg_data[hps_pkg::SPEED_W-1:0];
                hps_pkg::CFG_EVADE_OFFSET: r_offset <= i_cfg_data[hps_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = ((i_in.mode == hps_pkg::MODE_EVADE_LEFT) ||
                               (i_in.mode == hps_pkg::MODE_EVADE_RIGHT)) ? S_SERVO : S_WRAP;
                end
            end
            S_WRAP:    n_state = S_SUM;
            S_SUM:     n_state = S_MAC_P;
            S_MAC_P:   n_state = S_MAC_I;
            S_MAC_I:   n_state = S_MAC_D;
            S_MAC_D:   n_state = S_DRAIN;
            S_DRAIN:   n_state = S_SERVO;
            S_SERVO:   n_state = w_evade ? S_DONE : S_SPD_MUL;
            S_SPD_MUL: n_state = S_SPD_ACC;
            S_SPD_ACC: n_state = S_DIV_GO;
            S_DIV_GO:  n_state = S_DIV;
            S_DIV: begin
                if (!w_div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_raw = $signed({1'b0, r_head}) - $signed({1'b0, r_tgt});

    always_comb begin
        w_wrap = w_raw;
        if (w_raw > hps_pkg::WRAP_HALF) begin
            w_wrap = w_raw - hps_pkg::WRAP_FULL;
        end else if (w_raw < -hps_pkg::WRAP_HALF) begin
            w_wrap = w_raw + hps_pkg::WRAP_FULL;
        end
    end

    assign w_sum_ext = $signed({r_sum[hps_pkg::SUM_W-1], r_sum}) +
                       $signed((hps_pkg::SUM_W + 1)'(r_err));

    always_comb begin
        w_sum_sat = w_sum_ext[hps_pkg::SUM_W-1:0];
        if (w_sum_ext[hps_pkg::SUM_W] != w_sum_ext[hps_pkg::SUM_W-1]) begin
            w_sum_sat = w_sum_ext[hps_pkg::SUM_W] ?
                        $signed({1'b1, {(hps_pkg::SUM_W-1){1'b0}}}) :
                        $signed({1'b0, {(hps_pkg::SUM_W-1){1'b1}}});
        end
    end

    assign w_diff = $signed(hps_pkg::DIFF_W'(r_err)) - $signed(hps_pkg::DIFF_W'(r_prev));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_prev <= '0;
        end else begin
            if (r_state == S_SUM) begin
                r_sum <= w_sum_sat;
            end
            if (r_state == S_MAC_D) begin
                r_prev <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_in.mode;
            r_head <= i_in.heading;
            r_tgt <= i_in.target_heading;
        end
        if (r_state == S_WRAP) begin
            r_err <= w_wrap[hps_pkg::ERR_W-1:0];
        end
        if (r_state == S_SERVO) begin
            r_servo <= w_a3[hps_pkg::ANGLE_W-1:0];
        end
    end

    always_comb begin
        w_mac_ctl = '{clr: 1'b0, en: 1'b0, sub: 1'b1};
        w_mac_a = $signed({1'b0, r_gain_p});
        w_mac_b = hps_pkg::MUL_B_W'(r_err);
        case (r_state)
            S_IDLE: begin
                w_mac_ctl.clr = 1'b1;
            end
            S_MAC_P: begin
                w_mac_ctl.en = 1'b1;
            end
            S_MAC_I: begin
                w_mac_ctl.en = 1'b1;
                w_mac_a = $signed({1'b0, r_gain_i});
                w_mac_b = r_sum;
            end
            S_MAC_D: begin
                w_mac_ctl.en = 1'b1;
                w_mac_a = $signed({1'b0, r_gain_d});
                w_mac_b = hps_pkg::MUL_B_W'(w_diff);
            end
            S_SPD_MUL: begin
                w_mac_ctl = '{clr: 1'b1, en: 1'b1, sub: 1'b0};
                w_mac_a = $signed(hps_pkg::MUL_A_W'(w_spd_diff));
                w_mac_b = $signed(hps_pkg::MUL_B_W'(w_dev));
            end
            S_SPD_ACC: begin
                w_mac_ctl.sub = 1'b0;
            end
            default: begin
            end
        endcase
    end

    hps_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc)
    );

    assign w_floor = w_acc >>> hps_pkg::SHIFT;
    assign w_hold_a = $signed(w_floor[hps_pkg::CLAMP_W-1:0]) +
                      $signed(hps_pkg::CLAMP_W'({1'b0, r_center}));
    assign w_evade_a = (r_mode == hps_pkg::MODE_EVADE_LEFT) ?
                       ($signed({2'b00, r_center}) - $signed({3'b000, r_offset})) :
                       ($signed({2'b00, r_center}) + $signed({3'b000, r_offset}));
    assign w_lo_e = $signed({2'b00, r_center}) - $signed({3'b000, r_limit});
    assign w_hi_e = $signed({2'b00, r_center}) + $signed({3'b000, r_limit});
    assign w_a = w_evade ? hps_pkg::CLAMP_W'(w_evade_a) : w_hold_a;

    always_comb begin
        w_a1 = (w_a < hps_pkg::CLAMP_W'(w_lo_e)) ? hps_pkg::CLAMP_W'(w_lo_e) : w_a;
        w_a2 = (w_a1 > hps_pkg::CLAMP_W'(w_hi_e)) ? hps_pkg::CLAMP_W'(w_hi_e) : w_a1;
        if (w_a2 < 0) begin
            w_a3 = '0;
        end else if (w_a2 > hps_pkg::SERVO_MAX) begin
            w_a3 = hps_pkg::SERVO_MAX;
        end else begin
            w_a3 = w_a2;
        end
    end

    assign w_dev_s = $signed({1'b0, r_servo}) - $signed({1'b0, r_center});
    assign w_dev = w_dev_s[hps_pkg::ANGLE_W] ? hps_pkg::ANGLE_W'(-w_dev_s)
                                             : w_dev_s[hps_pkg::ANGLE_W-1:0];
    assign w_spd_ok = (r_cruise >= r_min) && (r_limit != '0);
    assign w_spd_diff = w_spd_ok ? (r_cruise - r_min) : '0;

    hps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (w_acc[hps_pkg::DIV_NUM_W-1:0]),
        .i_den   (r_limit),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign w_spd_sum = (hps_pkg::DIV_NUM_W + 1)'(r_min) + (hps_pkg::DIV_NUM_W + 1)'(w_quot);

    always_comb begin
        if (w_evade) begin
            w_speed = r_cruise;
        end else if (!w_spd_ok) begin
            w_speed = r_min;
        end else if (w_spd_sum > (hps_pkg::DIV_NUM_W + 1)'(r_cruise)) begin
            w_speed = r_cruise;
        end else begin
            w_speed = w_spd_sum[hps_pkg::SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fire) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_servo <= r_servo;
            r_out_speed <= w_speed;
            r_out_err <= w_evade ? '0 : r_err;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.servo_angle = r_out_servo;
    assign o_out.motor_speed = r_out_speed;
    assign o_out.heading_error = r_out_err;

endmodule

/* rtl/core/hps_checker.sv */
// Port-level assertions for the heading PID steering block, bound to the top level.
module hps_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [hps_pkg::ANGLE_W-1:0]  i_servo_angle
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output item dropped while the receiver stalls.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready)
        else $error("Input stays ready while an item is in work.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output item shown right after reset.");

    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_servo_angle <= 8'd180))
        else $error("Servo angle beyond its mechanical range.");

endmodule

bind heading_pid_steering hps_checker u_hps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_servo_angle (o_out.servo_angle)
);

/* test/hps_steer_check.sv */
// Steering command scoreboard: predicts each command from accepted ticks and compares.
module hps_steer_check
    import hps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hps_in_if                     in_ch,
    hps_out_if                    out_ch,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [ANGLE_W-1:0]       servo;
        logic [SPEED_W-1:0]       speed;
        logic signed [ERR_W-1:0]  err;
    } steer_cmd_t;

    steer_cmd_t expected_cmds[$];

    logic [GAIN_W-1:0]  gain_p, gain_i, gain_d;
    logic [ANGLE_W-1:0] center;
    logic [LIMIT_W-1:0] limit, offset;
    logic [SPEED_W-1:0] cruise, min_spd;
    longint             error_sum;
    int                 last_error;

    function automatic int clamp_angle(longint a);
        longint lo;
        longint hi;
        lo = longint'(center) - longint'(limit);
        hi = longint'(center) + longint'(limit);
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        if (a < 0) a = 0;
        if (a > 180) a = 180;
        return int'(a);
    endfunction

    function automatic steer_cmd_t predict_steering(logic [MODE_W-1:0] mode,
                                                    logic [HEAD_W-1:0] hd,
                                                    logic [HEAD_W-1:0] tg);
        steer_cmd_t cmd;
        int         err;
        int         servo;
        int         dev;
        int         q;
        int         speed;
        longint     acc;
        longint     corr;
        err = 0;
        if (mode == MODE_EVADE_LEFT || mode == MODE_EVADE_RIGHT) begin
            if (mode == MODE_EVADE_LEFT) begin
                servo = clamp_angle(longint'(center) - longint'(offset));
            end else begin
                servo = clamp_angle(longint'(center) + longint'(offset));
            end
            speed = int'(cruise);
        end else begin
            err = int'(hd) - int'(tg);
            if (err > 2880) err -= 5760;
            if (err < -2880) err += 5760;
            acc = error_sum + longint'(err);
            if (acc > longint'(32'sh7FFF_FFFF)) acc = longint'(32'sh7FFF_FFFF);
            if (acc < -longint'(64'd2147483648)) acc = -longint'(64'd2147483648);
            error_sum = acc;
            corr = longint'(gain_p) * longint'(err) + longint'(gain_i) * error_sum
                 + longint'(gain_d) * longint'(err - last_error);
            servo = clamp_angle(longint'(center) + ((-corr) >>> SHIFT));
            last_error = err;
            dev = servo - int'(center);
            if (dev < 0) dev = -dev;
            q = (limit != 0) ? ((int'(cruise) - int'(min_spd)) * dev) / int'(limit) : 0;
            speed = int'(min_spd) + q;
            if (speed > int'(cruise)) speed = int'(cruise);
            if (speed < int'(min_spd)) speed = int'(min_spd);
        end
        cmd.servo = servo[ANGLE_W-1:0];
        cmd.speed = speed[SPEED_W-1:0];
        cmd.err = err[ERR_W-1:0];
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        steer_cmd_t got;
        steer_cmd_t want;
        if (!i_rst_n) begin
            gain_p = RST_GAIN_P;
            gain_i = RST_GAIN_I;
            gain_d = RST_GAIN_D;
            center = RST_SERVO_CENTER;
            limit = RST_STEER_LIMIT;
            cruise = RST_CRUISE_SPEED;
            min_spd = RST_MIN_SPEED;
            offset = RST_EVADE_OFFSET;
            error_sum = 0;
            last_error = 0;
            expected_cmds.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAIN_P: gain_p = i_cfg_data;
                    CFG_GAIN_I: gain_i = i_cfg_data;
                    CFG_GAIN_D: gain_d = i_cfg_data;
                    CFG_SERVO_CENTER: center = i_cfg_data[ANGLE_W-1:0];
                    CFG_STEER_LIMIT: limit = i_cfg_data[LIMIT_W-1:0];
                    CFG_CRUISE_SPEED: cruise = i_cfg_data[SPEED_W-1:0];
                    CFG_MIN_SPEED: min_spd = i_cfg_data[SPEED_W-1:0];
                    CFG_EVADE_OFFSET: offset = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got.servo = out_ch.servo_angle;
                got.speed = out_ch.motor_speed;
                got.err = out_ch.heading_error;
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected item: servo %0d speed %0d error %0d", $time,
                             got.servo, got.speed, got.err);
                    o_mismatches++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        $display({"%0t: item mismatch: expected servo %0d speed %0d error %0d,",
                                  " got servo %0d speed %0d error %0d"}, $time,
                                 want.servo, want.speed, want.err,
                                 got.servo, got.speed, got.err);
                        o_mismatches++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_cmds.push_back(predict_steering(in_ch.mode, in_ch.heading,
                                                         in_ch.target_heading));
            end
        end
        o_pending = expected_cmds.size();
    end

endmodule

/* test/tb_heading_pid_steering.sv */
// Stimulus and verdict for the heading PID steering block.
module tb_heading_pid_steering;
    import hps_pkg::*;

    localparam logic [MODE_W-1:0] MODE_HOLD_ALT = 2'd3;

    typedef struct {
        logic [GAIN_W-1:0]  gp;
        logic [GAIN_W-1:0]  gi;
        logic [GAIN_W-1:0]  gd;
        logic [ANGLE_W-1:0] center;
        logic [LIMIT_W-1:0] limit;
        logic [SPEED_W-1:0] cruise;
        logic [SPEED_W-1:0] min_spd;
        logic [LIMIT_W-1:0] offset;
    } steer_setup_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    mismatches;
    int                    pending;
    bit                    no_idle;
    bit                    hold_off_req;

    hps_in_if  in_ch ();
    hps_out_if out_ch ();

    heading_pid_steering dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    hps_steer_check steer_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_tick(logic [MODE_W-1:0] mode, logic [HEAD_W-1:0] hd,
                             logic [HEAD_W-1:0] tg);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.heading <= hd;
        in_ch.target_heading <= tg;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random_tick();
        int                r;
        int                k;
        int                h;
        int                t;
        logic [MODE_W-1:0] mode;
        r = $urandom_range(0, 99);
        if (r < 6) mode = MODE_EVADE_LEFT;
        else if (r < 12) mode = MODE_EVADE_RIGHT;
        else if (r < 16) mode = MODE_HOLD_ALT;
        else mode = MODE_HOLD;
        k = $urandom_range(0, 99);
        if (k < 50) begin
            h = $urandom_range(0, 5759);
            t = (h + 5760 + $urandom_range(0, 128) - 64) % 5760;
        end else if (k < 85) begin
            h = $urandom_range(0, 5759);
            t = $urandom_range(0, 5759);
        end else begin
            h = $urandom_range(0, 8191);
            t = $urandom_range(0, 8191);
        end
        send_tick(mode, h[HEAD_W-1:0], t[HEAD_W-1:0]);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
    endtask

    task automatic apply_setup(steer_setup_t s);
        drain();
        write_reg(CFG_GAIN_P, s.gp);
        write_reg(CFG_GAIN_I, s.gi);
        write_reg(CFG_GAIN_D, s.gd);
        write_reg(CFG_SERVO_CENTER, CFG_DATA_W'(s.center));
        write_reg(CFG_STEER_LIMIT, CFG_DATA_W'(s.limit));
        write_reg(CFG_CRUISE_SPEED, CFG_DATA_W'(s.cruise));
        write_reg(CFG_MIN_SPEED, CFG_DATA_W'(s.min_spd));
        write_reg(CFG_EVADE_OFFSET, CFG_DATA_W'(s.offset));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic steer_setup_t random_setup();
        steer_setup_t s;
        s.gp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2047);
        s.gi = $urandom_range(0, 64);
        s.gd = $urandom_range(0, 1023);
        s.center = $urandom_range(0, 180);
        s.limit = $urandom_range(1, 90);
        s.cruise = $urandom_range(0, 255);
        s.min_spd = $urandom_range(0, 255);
        s.offset = $urandom_range(0, 90);
        return s;
    endfunction

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            int stall;
            @(negedge i_clk);
            if (hold_off_req) begin
                out_ch.ready <= 1'b0;
                hold_off_req = 1'b0;
                repeat (300) @(negedge i_clk);
            end else if (no_idle || $urandom_range(0, 99) < 60) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 60)
                                                     : $urandom_range(1, 3);
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        steer_setup_t setups[$];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_HOLD;
        in_ch.heading = '0;
        in_ch.target_heading = '0;
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(MODE_HOLD, 0, 0);
        send_tick(MODE_HOLD, 2880, 0);
        send_tick(MODE_HOLD, 0, 2880);
        send_tick(MODE_HOLD, 2881, 0);
        send_tick(MODE_HOLD, 0, 2881);
        send_tick(MODE_HOLD, 5759, 0);
        send_tick(MODE_HOLD, 0, 5759);
        send_tick(MODE_HOLD, 8191, 0);
        send_tick(MODE_HOLD, 0, 8191);
        send_tick(MODE_HOLD, 8191, 8191);
        send_tick(MODE_HOLD, 1000, 0);
        send_tick(MODE_HOLD, 0, 1000);
        send_tick(MODE_HOLD, 100, 80);
        send_tick(MODE_HOLD, 5000, 200);
        send_tick(MODE_EVADE_LEFT, 4000, 10);
        send_tick(MODE_EVADE_RIGHT, 8191, 8191);
        send_tick(MODE_HOLD_ALT, 120, 100);

        for (int n = 0; n < 200; n++) begin
            if (n == 40) hold_off_req = 1'b1;
            send_random_tick();
        end

        setups.push_back('{gp: 16'hFFFF, gi: 16'hFFFF, gd: 16'hFFFF, center: 8'd180,
                           limit: 7'd90, cruise: 8'd255, min_spd: 8'd0, offset: 7'd90});
        setups.push_back('{gp: 16'd0, gi: 16'd0, gd: 16'd0, center: 8'd0,
                           limit: 7'd1, cruise: 8'd0, min_spd: 8'd255, offset: 7'd0});
        setups.push_back('{gp: 16'd300, gi: 16'd2, gd: 16'd100, center: 8'd255,
                           limit: 7'd0, cruise: 8'd200, min_spd: 8'd30, offset: 7'd127});
        repeat (6) setups.push_back(random_setup());

        foreach (setups[i]) begin
            apply_setup(setups[i]);
            no_idle = (i == 1);
            repeat (i < 3 ? 100 : 90) send_random_tick();
            no_idle = 1'b0;
        end

        drain();
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
